// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define BTE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while the given disable term is high.
`define BTE_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/bte_pkg.sv
`default_nettype none
package bte_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } bte_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } bte_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic issue;
  } bte_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic plan_empty;
    logic plan_num;
    logic last_slot;
    logic out_free;
  } bte_status_t;

  localparam logic [16:0] LOAD_BASE   = 17'h00801;
  localparam logic [7:0]  TOKEN_FIRST = 8'h80;
  localparam logic [7:0]  TOKEN_LAST  = 8'hCB;
  localparam logic [7:0]  QUOTE_CHAR  = 8'h22;
  localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0]  SPACE_CHAR  = 8'h20;
  localparam logic [7:0]  DIGIT_ZERO  = 8'h30;
  localparam logic [6:0]  KW_ERROR    = 7'd76;
  localparam int          TEXT_BYTES  = 11;
  localparam int          CONV_STEPS  = 16;

  // Keyword text, right-aligned and zero-padded on the left
  function automatic logic [8*TEXT_BYTES-1:0] kw_text(input logic [6:0] idx);
    logic [8*TEXT_BYTES-1:0] t;
    case (idx)
      7'd0:  t = "END";
      7'd1:  t = "FOR";
      7'd2:  t = "NEXT";
      7'd3:  t = "DATA";
      7'd4:  t = "INPUT#";
      7'd5:  t = "INPUT";
      7'd6:  t = "DIM";
      7'd7:  t = "READ";
      7'd8:  t = "LET";
      7'd9:  t = "GOTO";
      7'd10: t = "RUN";
      7'd11: t = "IF";
      7'd12: t = "RESTORE";
      7'd13: t = "GOSUB";
      7'd14: t = "RETURN";
      7'd15: t = "REM";
      7'd16: t = "STOP";
      7'd17: t = "ON";
      7'd18: t = "WAIT";
      7'd19: t = "LOAD";
      7'd20: t = "SAVE";
      7'd21: t = "VERIFY";
      7'd22: t = "DEF";
      7'd23: t = "POKE";
      7'd24: t = "PRINT#";
      7'd25: t = "PRINT";
      7'd26: t = "CONT";
      7'd27: t = "LIST";
      7'd28: t = "CLR";
      7'd29: t = "CMD";
      7'd30: t = "SYS";
      7'd31: t = "OPEN";
      7'd32: t = "CLOSE";
      7'd33: t = "GET";
      7'd34: t = "NEW";
      7'd35: t = "TAB(";
      7'd36: t = "TO";
      7'd37: t = "FN";
      7'd38: t = "SPC(";
      7'd39: t = "THEN";
      7'd40: t = "NOT";
      7'd41: t = "STEP";
      7'd42: t = "+";
      7'd43: t = "-";
      7'd44: t = "*";
      7'd45: t = "/";
      7'd46: t = "^";
      7'd47: t = "AND";
      7'd48: t = "OR";
      7'd49: t = ">";
      7'd50: t = "=";
      7'd51: t = "<";
      7'd52: t = "SGN";
      7'd53: t = "INT";
      7'd54: t = "ABS";
      7'd55: t = "USR";
      7'd56: t = "FRE";
      7'd57: t = "POS";
      7'd58: t = "SQR";
      7'd59: t = "RND";
      7'd60: t = "LOG";
      7'd61: t = "EXP";
      7'd62: t = "COS";
      7'd63: t = "SIN";
      7'd64: t = "TAN";
      7'd65: t = "ATN";
      7'd66: t = "PEEK";
      7'd67: t = "LEN";
      7'd68: t = "STR$";
      7'd69: t = "VAL";
      7'd70: t = "ASC";
      7'd71: t = "CHR$";
      7'd72: t = "LEFT$";
      7'd73: t = "RIGHT$";
      7'd74: t = "MID$";
      7'd75: t = "GO";
      default: t = "***ERROR***";
    endcase
    return t;
  endfunction

  // Count the characters of a right-aligned text
  function automatic logic [3:0] kw_len(input logic [8*TEXT_BYTES-1:0] t);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < TEXT_BYTES; i++) begin
      if (t[i*8 +: 8] != 8'd0) n = n + 4'd1;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: hdl/bte_ctrl.sv
`default_nettype none
module bte_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire bte_pkg::bte_status_t st,
  output bte_pkg::bte_cmd_t         cmd,
  output logic                      in_stall
);
  import bte_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

  state_t     state;
  logic [3:0] conv_cnt;

  // Commands follow the state
  always_comb begin
    cmd.load      = (state == ST_IDLE) && in_valid;
    cmd.conv_step = (state == ST_CONV);
    cmd.issue     = (state == ST_EMIT) && st.out_free;
    in_stall      = (state != ST_IDLE);
  end

  // Sequence: take a byte, convert the line number if it has one, emit characters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      conv_cnt <= 4'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && !st.plan_empty) begin
            conv_cnt <= 4'd0;
            state    <= st.plan_num ? ST_CONV : ST_EMIT;
          end
        end
        ST_CONV: begin
          conv_cnt <= conv_cnt + 4'd1;
          if (conv_cnt == 4'(CONV_STEPS - 1)) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (st.out_free && st.last_slot) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/bte_datapath.sv
`default_nettype none
module bte_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bte_pkg::bte_cmd_t cmd,
  output bte_pkg::bte_status_t   st,
  input  wire bte_pkg::bte_in_t  in_data,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output bte_pkg::bte_out_t      out_data
);
  import bte_pkg::*;

  typedef enum logic [2:0] {
    PH_LOAD_LO, PH_LOAD_HI, PH_LINK_LO, PH_LINK_HI, PH_NUM_LO, PH_NUM_HI, PH_TEXT
  } phase_t;

  typedef enum logic [1:0] {SEG_NONE, SEG_NUM, SEG_TEXT} seg_kind_t;

  // Decoder state
  phase_t      phase, phase_next;
  logic [7:0]  link_low, link_low_next;
  logic [16:0] mem_address, mem_address_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  number_low, number_low_next;
  logic        quoted, quoted_next;
  logic        skip_rest, skip_rest_next;
  logic        finished, finished_next;

  // Emission plan
  seg_kind_t                   kind, kind_next;
  logic [TEXT_BYTES-1:0][7:0]  text, text_next;
  logic [3:0]                  len, len_next;
  logic                        has_space, has_space_next;
  logic                        has_nl, has_nl_next;
  logic [15:0]                 num_next;

  // Line number conversion
  logic [15:0]      bin;
  logic [4:0][3:0]  bcd, bcd_adj;

  // Character sequencing
  logic [3:0]  pos, seg_len, total, sel;
  logic [3:0]  num_len;
  logic [7:0]  ch;

  logic [7:0]         b;
  logic signed [17:0] gap;
  logic [17:0]        gap4;
  logic [15:0]        bl_dec;
  logic [8*TEXT_BYTES-1:0] kw;

  // Decode one byte into the next state and the characters it causes
  always_comb begin
    b                = in_data.byte_value;
    phase_next       = phase;
    link_low_next    = link_low;
    mem_address_next = mem_address;
    bytes_left_next  = bytes_left;
    number_low_next  = number_low;
    quoted_next      = quoted;
    skip_rest_next   = skip_rest;
    finished_next    = finished;
    kind_next        = SEG_NONE;
    text_next        = '0;
    len_next         = 4'd0;
    has_space_next   = 1'b0;
    has_nl_next      = 1'b0;
    num_next         = 16'd0;
    gap  = $signed({2'b00, b, link_low}) - $signed({1'b0, mem_address});
    gap4 = gap - 18'sd4;
    bl_dec = (bytes_left != 16'd0) ? bytes_left - 16'd1 : 16'd0;
    kw = kw_text((b <= TOKEN_LAST) ? b[6:0] : KW_ERROR);

    if (!finished) begin
      case (phase)
        PH_LOAD_LO: phase_next = PH_LOAD_HI;
        PH_LOAD_HI: phase_next = PH_LINK_LO;
        PH_LINK_LO: begin
          link_low_next = b;
          phase_next    = PH_LINK_HI;
        end
        PH_LINK_HI: begin
          // stop on a null link or a line too short to hold anything
          if ({b, link_low} == 16'd0 || gap < 18'sd4) begin
            finished_next = 1'b1;
          end else begin
            bytes_left_next  = gap4[15:0];
            mem_address_next = {1'b0, b, link_low};
            phase_next       = PH_NUM_LO;
          end
        end
        PH_NUM_LO: begin
          number_low_next = b;
          phase_next      = PH_NUM_HI;
        end
        PH_NUM_HI: begin
          kind_next      = SEG_NUM;
          num_next       = {b, number_low};
          has_space_next = 1'b1;
          quoted_next    = 1'b0;
          skip_rest_next = 1'b0;
          if (bytes_left == 16'd0) begin
            has_nl_next = 1'b1;
            phase_next  = PH_LINK_LO;
          end else begin
            phase_next = PH_TEXT;
          end
        end
        PH_TEXT: begin
          if (!skip_rest) begin
            if (quoted && b != QUOTE_CHAR) begin
              kind_next    = SEG_TEXT;
              text_next[0] = b;
              len_next     = 4'd1;
            end else if (b >= TOKEN_FIRST) begin
              kind_next = SEG_TEXT;
              text_next = kw;
              len_next  = kw_len(kw);
            end else if (b == 8'd0) begin
              has_nl_next    = 1'b1;
              skip_rest_next = 1'b1;
            end else begin
              kind_next    = SEG_TEXT;
              text_next[0] = b;
              len_next     = 4'd1;
              if (b == QUOTE_CHAR) quoted_next = !quoted;
            end
          end
          bytes_left_next = bl_dec;
          if (bl_dec == 16'd0) begin
            if (!skip_rest_next) has_nl_next = 1'b1;
            phase_next = PH_LINK_LO;
          end
        end
        default: phase_next = PH_LOAD_LO;
      endcase
    end

    // Close a truncated line, then start over for the next file
    if (in_data.last_byte) begin
      if (!finished_next) begin
        if (phase_next == PH_NUM_LO) begin
          kind_next      = SEG_NUM;
          num_next       = 16'd0;
          has_space_next = 1'b1;
          has_nl_next    = 1'b1;
        end else if (phase_next == PH_NUM_HI) begin
          kind_next      = SEG_NUM;
          num_next       = {8'd0, number_low_next};
          has_space_next = 1'b1;
          has_nl_next    = 1'b1;
        end else if (phase_next == PH_TEXT && !skip_rest_next) begin
          has_nl_next = 1'b1;
        end
      end
      phase_next       = PH_LOAD_LO;
      link_low_next    = 8'd0;
      mem_address_next = LOAD_BASE;
      bytes_left_next  = 16'd0;
      number_low_next  = 8'd0;
      quoted_next      = 1'b0;
      skip_rest_next   = 1'b0;
      finished_next    = 1'b0;
    end
  end

  // Add three to each digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // Pick the character at the current slot and form the status for the controller
  always_comb begin
    if (bcd[4] != 4'd0)      num_len = 4'd5;
    else if (bcd[3] != 4'd0) num_len = 4'd4;
    else if (bcd[2] != 4'd0) num_len = 4'd3;
    else if (bcd[1] != 4'd0) num_len = 4'd2;
    else                     num_len = 4'd1;
    case (kind)
      SEG_NUM:  seg_len = num_len;
      SEG_TEXT: seg_len = len;
      default:  seg_len = 4'd0;
    endcase
    total = seg_len + {3'd0, has_space} + {3'd0, has_nl};
    sel   = seg_len - 4'd1 - pos;
    if (pos < seg_len) begin
      ch = (kind == SEG_NUM) ? (DIGIT_ZERO | {4'd0, bcd[sel[2:0]]}) : text[sel];
    end else if (pos == seg_len && has_space) begin
      ch = SPACE_CHAR;
    end else begin
      ch = NEWLINE_CHAR;
    end
    st.plan_empty = (kind_next == SEG_NONE) && !has_nl_next;
    st.plan_num   = (kind_next == SEG_NUM);
    st.last_slot  = (pos == total - 4'd1);
    st.out_free   = !out_valid || !out_stall;
  end

  // Decoder state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LOAD_LO;
      link_low    <= 8'd0;
      mem_address <= LOAD_BASE;
      bytes_left  <= 16'd0;
      number_low  <= 8'd0;
      quoted      <= 1'b0;
      skip_rest   <= 1'b0;
      finished    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load) begin
        phase       <= phase_next;
        link_low    <= link_low_next;
        mem_address <= mem_address_next;
        bytes_left  <= bytes_left_next;
        number_low  <= number_low_next;
        quoted      <= quoted_next;
        skip_rest   <= skip_rest_next;
        finished    <= finished_next;
      end
      if (cmd.issue) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Plan, conversion and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind      <= kind_next;
      text      <= text_next;
      len       <= len_next;
      has_space <= has_space_next;
      has_nl    <= has_nl_next;
      bin       <= num_next;
      bcd       <= '0;
      pos       <= 4'd0;
    end else if (cmd.conv_step) begin
      {bcd, bin} <= {bcd_adj[4][2:0], bcd_adj[3], bcd_adj[2], bcd_adj[1], bcd_adj[0],
                     bin, 1'b0};
    end else if (cmd.issue) begin
      pos <= pos + 4'd1;
    end
    if (cmd.issue) begin
      out_data.out_char    <= ch;
      out_data.last_of_run <= st.last_slot;
    end
  end

endmodule
`default_nettype wire

// File: hdl/basic_token_line_expander_top.sv
`default_nettype none
// Channel   Direction  Payload      Handshake
// in        input      bte_in_t     in_valid / in_stall
// out       output     bte_out_t    out_valid / out_stall
//
// A byte that prints nothing is taken and the block stays idle. A byte that
// prints a line number first passes through the binary-to-decimal shifter,
// then emits one character per cycle while the output is not stalled; other
// bytes emit their characters (up to 12) the same way.
// Synchronous reset returns the decoder to the start of a file.
module basic_token_line_expander_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bte_pkg::bte_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bte_pkg::bte_out_t      out_data
);
  import bte_pkg::*;

  bte_cmd_t    cmd;
  bte_status_t st;

  bte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  bte_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: hdl/bte_checker.sv
`default_nettype none
`include "assert_macros.svh"
module bte_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire bte_pkg::bte_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire bte_pkg::bte_out_t out_data
);
  import bte_pkg::*;

  logic out_wait;
  logic in_wait;
  logic in_idle;
  logic mid_run;

  assign out_wait = out_valid && out_stall;
  assign in_wait  = in_valid && in_stall;
  assign in_idle  = !out_valid && !in_stall;
  assign mid_run  = out_valid && !out_data.last_of_run;

  // Hold a stalled output transaction
  `BTE_ASSERT_NEXT(a_out_hold, clk, rst, out_wait, out_valid && $stable(out_data), "output moved")

  // Hold a stalled input transaction
  `BTE_ASSERT_NEXT(a_in_hold, clk, rst, in_wait, in_valid && $stable(in_data), "input moved")

  // Clear the output after reset
  `BTE_ASSERT_NEXT(a_rst_clear, clk, 1'b0, rst, !out_valid, "output valid after reset")

  // Block input while a run is still unfinished
  `BTE_ASSERT_IMPL(a_run_blocks, clk, rst, mid_run, in_stall, "input taken mid-run")

  // Start output only after a byte has been taken
  `BTE_ASSERT_NEXT(a_idle_out, clk, rst, in_idle, !out_valid, "output without a transaction")

endmodule

bind basic_token_line_expander_top bte_checker u_bte_checker (.*);
`default_nettype wire
